@@ hdl/lsn_waiter_table_assert.svh @@
// Assertion macros shared by the checker of the waiter table
`ifndef LSN_WAITER_TABLE_ASSERT_SVH
`define LSN_WAITER_TABLE_ASSERT_SVH

// Property that must hold at every clock edge outside reset
`define LWT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next one
`define LWT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lwt_pkg.sv @@
// Shared constants and types of the waiter table
package lwt_pkg;

	localparam int NUM_SLOTS = 64;
	localparam int SLOT_W    = 7;
	localparam int IDX_W     = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 2);
	localparam int POS_W     = 64;
	localparam int REQ_W     = 2;
	localparam int Q_DEPTH   = 2;
	localparam int QPTR_W    = $clog2(Q_DEPTH);
	localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

	localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_REM,
		OP_ADV,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [IDX_W-1:0]  idx;
		logic [POS_W-1:0]  pos;
	} cmd_t;

endpackage

@@ hdl/lwt_front.sv @@
// Front end: accepts requests, classifies them and queues commands for the back end
module lwt_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [lwt_pkg::REQ_W-1:0]  req_type,
	input  logic [lwt_pkg::SLOT_W-1:0] slot_id,
	input  logic [lwt_pkg::POS_W-1:0]  position,
	output lwt_pkg::cmd_t              cmd,
	output logic                       cmd_valid,
	input  logic                       cmd_ready
);
	import lwt_pkg::*;

	cmd_t              cmd_in;
	logic              slot_ok;
	logic              push;
	logic              pop;
	cmd_t              fifo_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_comb begin
		slot_ok     = (slot_id != '0) && (slot_id <= SLOT_W'(NUM_SLOTS));
		cmd_in.slot = slot_id;
		cmd_in.idx  = IDX_W'(slot_id - SLOT_W'(1));
		cmd_in.pos  = position;
		// an add of zero is a remove; adds and removes of out-of-range slots do nothing
		priority if (req_type == REQ_ADD && slot_ok && position != '0) begin
			cmd_in.op = OP_ADD;
		end else if ((req_type == REQ_ADD || req_type == REQ_REMOVE) && slot_ok) begin
			cmd_in.op = OP_REM;
		end else if (req_type == REQ_ADVANCE) begin
			cmd_in.op = OP_ADV;
		end else begin
			cmd_in.op = OP_NOP;
		end
	end

	assign in_ready  = (count_q != QCNT_W'(Q_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/lwt_back.sv @@
// Back end: slot memory, minimum and highest-slot tracking, scans and result register
module lwt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lwt_pkg::cmd_t              cmd,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lwt_pkg::SLOT_W-1:0] woken_slot,
	output logic                       wake_valid,
	output logic [lwt_pkg::POS_W-1:0]  min_waited,
	output logic                       last
);
	import lwt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RM_CHK = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_FIN    = 4'b1000
	} state_t;

	state_t              state_q;
	logic [POS_W-1:0]    slot_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] vld_q;
	logic [SLOT_W-1:0]   highest_q;
	logic [POS_W-1:0]    min_q;
	cmd_t                cur_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                d_v_q;
	logic                d_occ_q;
	logic [SLOT_W-1:0]   d_idx_q;
	logic [POS_W-1:0]    rd_data_q;
	logic                hold_v_q;
	logic [SLOT_W-1:0]   hold_idx_q;
	logic                need_min_q;
	logic                need_hi_q;
	logic [SLOT_W-1:0]   last_occ_q;
	logic                ov_q;
	logic [SLOT_W-1:0]   o_slot_q;
	logic                o_wake_q;
	logic [POS_W-1:0]    o_min_q;
	logic                o_last_q;

	logic             pop;
	logic             scan_more;
	logic             hit;
	logic             out_free;
	logic             stall;
	logic             issue;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             scan_done;
	logic             emit_mid;
	logic             emit_fin;
	logic             need_min;
	logic             need_hi;

	always_comb begin
		pop       = (state_q == ST_IDLE) && cmd_valid;
		scan_more = (cnt_q <= CNT_W'(highest_q));
		hit       = d_v_q && d_occ_q && (rd_data_q <= cur_q.pos);
		out_free  = !ov_q || out_ready;
		// a second hit can only move on once the held one has a free output slot
		stall     = (state_q == ST_SCAN) && (cur_q.op == OP_ADV) && hit && hold_v_q
			&& !out_free;
		issue     = (state_q == ST_SCAN) && scan_more && !stall;
		rd_addr   = pop ? cmd.idx : IDX_W'(cnt_q - CNT_W'(1));
		rd_en     = (pop && cmd.op == OP_REM) || issue;
		scan_done = (state_q == ST_SCAN) && !scan_more && !d_v_q;
		emit_mid  = (state_q == ST_SCAN) && (cur_q.op == OP_ADV) && hit && hold_v_q
			&& out_free;
		emit_fin  = (state_q == ST_FIN) && out_free;
		need_min  = d_occ_q && (rd_data_q == min_q);
		need_hi   = (highest_q == cur_q.slot);
	end

	assign cmd_ready  = (state_q == ST_IDLE);
	assign out_valid  = ov_q;
	assign woken_slot = o_slot_q;
	assign wake_valid = o_wake_q;
	assign min_waited = o_min_q;
	assign last       = o_last_q;

	always_ff @(posedge clk) begin
		if (pop && cmd.op == OP_ADD) begin
			slot_mem[cmd.idx] <= cmd.pos;
		end
		if (rd_en) begin
			rd_data_q <= slot_mem[rd_addr];
			d_occ_q   <= vld_q[rd_addr];
			d_idx_q   <= SLOT_W'(cnt_q);
		end
		if (pop) begin
			cur_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vld_q      <= '0;
			highest_q  <= '0;
			min_q      <= '1;
			cnt_q      <= '0;
			d_v_q      <= 1'b0;
			hold_v_q   <= 1'b0;
			hold_idx_q <= '0;
			need_min_q <= 1'b0;
			need_hi_q  <= 1'b0;
			last_occ_q <= '0;
			ov_q       <= 1'b0;
			o_slot_q   <= '0;
			o_wake_q   <= 1'b0;
			o_min_q    <= '0;
			o_last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						hold_v_q <= 1'b0;
						d_v_q    <= 1'b0;
						cnt_q    <= CNT_W'(1);
						unique case (cmd.op)
							OP_ADD: begin
								vld_q[cmd.idx] <= 1'b1;
								if (highest_q < cmd.slot) begin
									highest_q <= cmd.slot;
								end
								if (cmd.pos < min_q) begin
									min_q <= cmd.pos;
								end
								state_q <= ST_FIN;
							end
							OP_REM: begin
								vld_q[cmd.idx] <= 1'b0;
								state_q        <= ST_RM_CHK;
							end
							OP_ADV: begin
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_RM_CHK: begin
					need_min_q <= need_min;
					need_hi_q  <= need_hi;
					last_occ_q <= '0;
					if (need_min) begin
						min_q <= '1;
					end
					state_q <= (need_min || need_hi) ? ST_SCAN : ST_FIN;
				end
				ST_SCAN: begin
					if (!stall) begin
						d_v_q <= issue;
						if (issue) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (d_v_q) begin
							if (cur_q.op == OP_ADV) begin
								if (hit) begin
									hold_v_q   <= 1'b1;
									hold_idx_q <= d_idx_q;
								end
							end else if (d_occ_q) begin
								if (need_min_q && rd_data_q < min_q) begin
									min_q <= rd_data_q;
								end
								if (need_hi_q) begin
									last_occ_q <= d_idx_q;
								end
							end
						end
					end
					if (scan_done) begin
						// keep the mark when nothing at or below it is occupied
						if (cur_q.op == OP_REM && need_hi_q && last_occ_q != '0) begin
							highest_q <= last_occ_q;
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			priority if (emit_mid) begin
				ov_q     <= 1'b1;
				o_slot_q <= hold_idx_q;
				o_wake_q <= 1'b1;
				o_min_q  <= min_q;
				o_last_q <= 1'b0;
			end else if (emit_fin) begin
				ov_q     <= 1'b1;
				o_slot_q <= hold_v_q ? hold_idx_q : '0;
				o_wake_q <= hold_v_q;
				o_min_q  <= min_q;
				o_last_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/lsn_waiter_table.sv @@
// Waiter table for awaited log positions. Requests enter a two-entry command
// queue and are carried out one at a time by the back end, which owns a
// 64-entry slot memory with one read port. A remove rescans slots 1 up to the
// highest slot, one memory read per cycle, when the removed target was the
// minimum or the slot was the highest in use. An advance scans the same range
// and delivers one transfer per woken slot, the last one flagged, or a single
// final transfer without a wake when none is woken; each result is held until
// the next hit or the end of the scan so the final flag is known, and a stalled
// output pauses the scan. Reset empties the table at once through per-slot
// valid flags, so no clearing pass is needed.
module lsn_waiter_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [lwt_pkg::REQ_W-1:0]  req_type,
	input  logic [lwt_pkg::SLOT_W-1:0] slot_id,
	input  logic [lwt_pkg::POS_W-1:0]  position,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lwt_pkg::SLOT_W-1:0] woken_slot,
	output logic                       wake_valid,
	output logic [lwt_pkg::POS_W-1:0]  min_waited,
	output logic                       last
);
	import lwt_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	lwt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.slot_id   (slot_id),
		.position  (position),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	lwt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.woken_slot (woken_slot),
		.wake_valid (wake_valid),
		.min_waited (min_waited),
		.last       (last)
	);

endmodule

@@ hdl/lwt_checker.sv @@
// Port-level checks of the waiter table, bound to the top level
`include "lsn_waiter_table_assert.svh"

module lwt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [lwt_pkg::SLOT_W-1:0] woken_slot,
	input logic                       wake_valid,
	input logic [lwt_pkg::POS_W-1:0]  min_waited,
	input logic                       last
);
	import lwt_pkg::*;

	`LWT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(woken_slot) && $stable(wake_valid) && $stable(min_waited) && $stable(last), "result changed while stalled")
	`LWT_ASSERT(a_nowake_is_last, !(out_valid && !wake_valid) || (last && woken_slot == '0), "result without wake must be a final one with slot zero")
	`LWT_ASSERT(a_wake_slot_range, !(out_valid && wake_valid) || (woken_slot != '0 && woken_slot <= SLOT_W'(NUM_SLOTS)), "woken slot out of range")

endmodule

bind lsn_waiter_table lwt_checker u_lwt_checker (.*);

@@ bench/tb_lsn_waiter_table.sv @@
// Self-checking testbench for the waiter table: add, remove and advance with wake checks
module tb_lsn_waiter_table;
	timeunit 1ns;
	timeprecision 1ps;

	import lwt_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 150;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 80;

	class wake_scoreboard;
		typedef struct packed {
			logic [SLOT_W-1:0] slot;
			logic              hit;
			logic [POS_W-1:0]  min_pos;
			logic              last;
		} wake_t;

		logic [POS_W-1:0] target [1:NUM_SLOTS];
		int               top_slot;
		logic [POS_W-1:0] min_target;
		wake_t            pending_wakes [$];
		int               errors;
		int               requests;
		int               results;
		int               wakes;

		function new();
			for (int i = 1; i <= NUM_SLOTS; i++)
				target[i] = '0;
			top_slot = 0;
			min_target = '1;
			errors = 0;
			requests = 0;
			results = 0;
			wakes = 0;
		endfunction

		function void push_result(int slot, logic hit, logic last);
			wake_t w;
			w.slot = SLOT_W'(slot);
			w.hit = hit;
			w.min_pos = min_target;
			w.last = last;
			pending_wakes.push_back(w);
		endfunction

		function void clear_slot(int s);
			logic [POS_W-1:0] old;
			int scan_end;
			old = target[s];
			target[s] = '0;
			// stale minimum only gets rebuilt when the cleared target matches it
			if (old != 0 && old == min_target) begin
				min_target = '1;
				scan_end = top_slot;
				for (int i = 1; i <= scan_end; i++)
					if (target[i] != 0 && target[i] < min_target)
						min_target = target[i];
			end
			// lower the mark only if some slot at or below it is still occupied
			if (top_slot == s) begin
				for (int i = s; i >= 1; i--) begin
					if (target[i] != 0) begin
						top_slot = i;
						break;
					end
				end
			end
		endfunction

		function void note_request(logic [REQ_W-1:0] rq, logic [SLOT_W-1:0] sid,
				logic [POS_W-1:0] pos);
			bit in_range;
			int s;
			int last_hit;
			in_range = sid >= 1 && sid <= NUM_SLOTS;
			s = int'(sid);
			last_hit = 0;
			requests++;
			if (rq == REQ_ADD && in_range) begin
				if (pos == 0) begin
					clear_slot(s);
				end else begin
					if (top_slot < s)
						top_slot = s;
					target[s] = pos;
					if (pos < min_target)
						min_target = pos;
				end
			end else if (rq == REQ_REMOVE && in_range) begin
				clear_slot(s);
			end else if (rq == REQ_ADVANCE) begin
				for (int i = 1; i <= top_slot; i++)
					if (target[i] != 0 && target[i] <= pos)
						last_hit = i;
				for (int i = 1; i <= last_hit; i++)
					if (target[i] != 0 && target[i] <= pos)
						push_result(i, 1'b1, i == last_hit);
				if (last_hit != 0)
					return;
			end
			push_result(0, 1'b0, 1'b1);
		endfunction

		function void check_result(logic [SLOT_W-1:0] slot, logic hit,
				logic [POS_W-1:0] min_pos, logic last);
			wake_t want;
			results++;
			if (hit)
				wakes++;
			if (pending_wakes.size() == 0) begin
				$display("%0t: unexpected result: slot %0d valid %0b min %h last %0b",
					$time, slot, hit, min_pos, last);
				errors++;
				return;
			end
			want = pending_wakes.pop_front();
			if (slot !== want.slot) begin
				$display("%0t: woken_slot expected %0d, actual %0d", $time, want.slot, slot);
				errors++;
			end
			if (hit !== want.hit) begin
				$display("%0t: wake_valid expected %0b, actual %0b", $time, want.hit, hit);
				errors++;
			end
			if (min_pos !== want.min_pos) begin
				$display("%0t: min_waited expected %h, actual %h", $time, want.min_pos, min_pos);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last expected %0b, actual %0b", $time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [REQ_W-1:0]   req_type;
	logic [SLOT_W-1:0]  slot_id;
	logic [POS_W-1:0]   position;
	logic               out_valid;
	logic               out_ready;
	logic [SLOT_W-1:0]  woken_slot;
	logic               wake_valid;
	logic [POS_W-1:0]   min_waited;
	logic               last;

	wake_scoreboard     sb;
	logic [POS_W-1:0]   lsn_base;
	bit                 hold_receiver = 1'b0;
	bit                 no_idle = 1'b0;

	lsn_waiter_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.slot_id    (slot_id),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.woken_slot (woken_slot),
		.wake_valid (wake_valid),
		.min_waited (min_waited),
		.last       (last)
	);

	always #5 clk = ~clk;

	function automatic logic [POS_W-1:0] wide_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [SLOT_W-1:0] near_slot();
		if ($urandom_range(0, 9) == 0)
			return SLOT_W'($urandom_range(1, NUM_SLOTS));
		return SLOT_W'($urandom_range(1, 12));
	endfunction

	task automatic send_request(input logic [REQ_W-1:0] rq, input logic [SLOT_W-1:0] sid,
			input logic [POS_W-1:0] pos);
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= rq;
		slot_id <= sid;
		position <= pos;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		sb.note_request(rq, sid, pos);
	endtask

	task automatic sender_gap();
		int n;
		if (no_idle || $urandom_range(0, 2) != 0)
			return;
		n = $urandom_range(1, 7);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// drop valid and hold until every expected result has come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_wakes.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_request();
		int pick;
		logic [SLOT_W-1:0] sid;
		logic [POS_W-1:0] pos;
		pick = $urandom_range(0, 99);
		sid = near_slot();
		pos = lsn_base + $urandom_range(1, 2000);
		if (pick < 38) begin
			send_request(REQ_ADD, sid, pos);
		end else if (pick < 60) begin
			send_request(REQ_REMOVE, sid, pos);
		end else if (pick < 88) begin
			lsn_base = lsn_base + $urandom_range(0, 400);
			send_request(REQ_ADVANCE, SLOT_W'($urandom_range(0, 127)),
				lsn_base + $urandom_range(0, 1500));
		end else begin
			case ($urandom_range(0, 4))
				0: send_request(REQ_UNUSED, SLOT_W'($urandom_range(0, 127)), wide_word());
				1: send_request(REQ_W'($urandom_range(0, 1)),
					$urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127)), pos);
				2: send_request(REQ_ADD, sid, '0);
				3: send_request(REQ_ADVANCE, SLOT_W'($urandom_range(0, 127)), wide_word());
				default: send_request(REQ_ADD, sid, wide_word());
			endcase
		end
		sender_gap();
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_result(woken_slot, wake_valid, min_waited, last);
	end

	// receiver: random ready bursts, one long hold-off on request
	initial begin
		int span;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_receiver) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_receiver = 1'b0;
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				span = $urandom_range(1, 7);
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (span - 1) @(negedge clk);
			end else begin
				span = $urandom_range(1, 16);
				@(negedge clk);
				out_ready <= 1'b1;
				repeat (span - 1) @(negedge clk);
			end
		end
	end

	// watchdog: end the run after a long stretch with no transfer on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_ready === 1'b1)
					|| (out_valid === 1'b1 && out_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles, %0d results outstanding",
			$time, STALL_LIMIT, sb.pending_wakes.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_ADD;
		slot_id = '0;
		position = '0;
		lsn_base = {1'b0, 31'($urandom), $urandom};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, out-of-range slots and the unused code
		send_request(REQ_ADVANCE, 7'd0, '1);
		send_request(REQ_ADD, 7'd127, 64'd5);
		send_request(REQ_ADD, 7'd0, 64'd5);
		send_request(REQ_REMOVE, 7'd65, '0);
		send_request(REQ_UNUSED, 7'd1, '1);
		// extremes of slot and position
		send_request(REQ_ADD, 7'd1, 64'd1);
		send_request(REQ_ADD, 7'd64, '1);
		send_request(REQ_ADD, 7'd7, 64'h5555_5555_5555_5555);
		send_request(REQ_ADD, 7'd9, 64'haaaa_aaaa_aaaa_aaaa);
		send_request(REQ_ADVANCE, 7'd127, '1);
		send_request(REQ_ADVANCE, 7'd0, '0);
		// overwrite leaves the minimum stale, empty and highest removes, add of zero
		send_request(REQ_ADD, 7'd1, 64'd1000);
		send_request(REQ_REMOVE, 7'd3, '0);
		send_request(REQ_REMOVE, 7'd64, '0);
		send_request(REQ_ADD, 7'd9, '0);
		send_request(REQ_ADD, 7'd2, 64'd20);
		send_request(REQ_ADD, 7'd3, 64'd10);
		send_request(REQ_ADD, 7'd4, 64'd1);
		send_request(REQ_REMOVE, 7'd4, '0);
		send_request(REQ_ADVANCE, 7'd5, 64'd20);
		// empty the table; the mark stays put when nothing is left below it
		send_request(REQ_REMOVE, 7'd7, '0);
		send_request(REQ_REMOVE, 7'd3, '0);
		send_request(REQ_REMOVE, 7'd2, '0);
		send_request(REQ_REMOVE, 7'd1, '0);
		send_request(REQ_ADVANCE, 7'd0, '1);
		settle();

		repeat (25) random_request();
		settle();

		// fill some slots, then stall the output while advances keep coming
		for (int i = 1; i <= 8; i++)
			send_request(REQ_ADD, 7'(i), lsn_base + 64'(i * 10));
		hold_receiver = 1'b1;
		repeat (8) send_request(REQ_ADVANCE, SLOT_W'($urandom_range(0, 127)),
			lsn_base + 64'd5000);
		settle();

		repeat (20) random_request();
		no_idle = 1'b1;
		repeat (15) random_request();
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests: add, remove, advance, out-of-range and unused codes,",
			sb.requests);
		$display("with %0d results checked (%0d wakes) under random and long output stalls.",
			sb.results, sb.wakes);
		if (sb.errors == 0 && sb.pending_wakes.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+hdl
hdl/lwt_pkg.sv
hdl/lwt_front.sv
hdl/lwt_back.sv
hdl/lsn_waiter_table.sv
hdl/lwt_checker.sv
bench/tb_lsn_waiter_table.sv
